// File: design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types, register indexes, step codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

    localparam int unsigned CAL_COUNT   = 5;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CAL_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CAL_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CAL_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CAL_B1_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CAL_MC_MD   = 3'd4;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] B4_BIAS     = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] P_SQ_COEF   = 32'd3038;
    localparam logic [31:0] P_LIN_COEF  = 32'hFFFF_E343;
    localparam logic [31:0] P_OFFSET    = 32'd3791;

    typedef enum logic [4:0] {
        OP_T_MUL,
        OP_T_X1,
        OP_T_DEN,
        OP_T_DIVS,
        OP_T_X2,
        OP_T_B5,
        OP_P_B6,
        OP_P_SQM,
        OP_P_SQ,
        OP_P_M1,
        OP_P_X1,
        OP_P_X2,
        OP_P_B3,
        OP_P_X3,
        OP_P_B4M,
        OP_P_B4,
        OP_P_B7,
        OP_P_DIVS,
        OP_P_P,
        OP_P_PM,
        OP_P_PX,
        OP_P_Y1,
        OP_P_Y2,
        OP_P_V
    } op_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        op_t  op;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_zero;
        logic div_done;
    } status_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] x);
        sext16 = {{16{x[15]}}, x};
    endfunction

endpackage

`default_nettype wire

// File: design/bsc_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one raw sensor reading per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [23:0] raw_value;

    modport source (output valid, output kind, output raw_value, input ready);
    modport sink   (input valid, input kind, input raw_value, output ready);
endinterface

`default_nettype wire

// File: design/bsc_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one compensated result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] value;
    logic        divide_error;

    modport source (output valid, output result_kind, output value, output divide_error,
                    input ready);
    modport sink   (input valid, input result_kind, input value, input divide_error,
                    output ready);
endinterface

`default_nettype wire

// File: design/barometric_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Integer temperature and pressure compensation from calibration words.
//
//   Channel    Dir  Item contents
//   in_item    in   kind, raw_value
//   out_item   out  result_kind, value, divide_error
//   cfg        in   cfg_we, cfg_index, cfg_data (write only)
//
// A temperature or pressure item goes from acceptance to the output register
// through its sequence of datapath steps, with most of its time spent in the divider.
// An item that hits a zero divisor skips the division and finishes early.
// One item is worked at a time; the next is taken while a result waits.
// Reset clears the calibration registers and the kept B5 term.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_sensor_compensation_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    bsc_in_if.sink                               in_item,
    bsc_out_if.source                            out_item,
    input  wire logic                            cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsc_pkg::*;

    cmd_t    cmd;
    status_t status;

    bsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_kind   (in_item.kind),
        .in_ready  (in_item.ready),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .cmd       (cmd),
        .status    (status)
    );

    bsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (in_item.kind),
        .in_raw    (in_item.raw_value),
        .cmd       (cmd),
        .status    (status),
        .out_kind  (out_item.result_kind),
        .out_value (out_item.value),
        .out_err   (out_item.divide_error)
    );
endmodule

`default_nettype wire

// File: design/bsc_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic [31:0]      quotient,
    output logic             done
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
            end
            else
            begin
                rem_next = trial[31:0];
            end
            quo_next = {quo_reg[30:0], ~trial[32]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

`default_nettype wire

// File: design/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// Compensation controller
// Sequences the datapath steps and runs both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_kind,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bsc_pkg::cmd_t       cmd,
    input  wire bsc_pkg::status_t status
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIVW,
        ST_PUT
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   load_out;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_PUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    op_next    = (in_kind == KIND_PRESS) ? OP_P_B6 : OP_T_MUL;
                end
            end
            ST_RUN:
            begin
                case (op_reg)
                    OP_T_DIVS, OP_P_DIVS:
                    begin
                        state_next = status.div_zero ? ST_PUT : ST_DIVW;
                    end
                    OP_T_B5, OP_P_V:
                    begin
                        state_next = ST_PUT;
                    end
                    default:
                    begin
                        op_next = op_t'(5'(op_reg) + 5'd1);
                    end
                endcase
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    state_next = ST_RUN;
                    op_next    = op_t'(5'(op_reg) + 5'd1);
                end
            end
            ST_PUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_T_MUL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign cmd.load_in  = accept;
    assign cmd.exec     = (state_reg == ST_RUN);
    assign cmd.op       = op_reg;
    assign cmd.load_out = load_out;
endmodule

`default_nettype wire

// File: design/bsc_dp.sv
// ----------------------------------------------------------------------------
// Compensation datapath
// Calibration registers, shared multiplier, divider and working registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_kind,
    input  wire logic [23:0]                         in_raw,
    input  wire bsc_pkg::cmd_t                       cmd,
    output bsc_pkg::status_t                         status,
    output logic                                     out_kind,
    output logic [31:0]                              out_value,
    output logic                                     out_err
);
    import bsc_pkg::*;

    logic [31:0] cal_reg [CAL_COUNT];
    logic [31:0] b5_reg;

    logic        kind_reg;
    logic [23:0] raw_reg;
    logic [31:0] m_reg, ta_reg, tb_reg, tc_reg;
    logic [31:0] b3_reg, b4_reg, b6_reg, sq_reg, p_reg;
    logic        neg_reg, dbl_reg;
    logic [31:0] res_value_reg;
    logic        res_err_reg;
    logic        okind_reg, oerr_reg;
    logic [31:0] ovalue_reg;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] mul_a, mul_b, num, pshr;
    logic [31:0] div_dividend, div_divisor, div_q;
    logic        div_start, is_divs;

    assign ac1 = sext16(cal_reg[CAL_AC1_AC2][31:16]);
    assign ac2 = sext16(cal_reg[CAL_AC1_AC2][15:0]);
    assign ac3 = sext16(cal_reg[CAL_AC3_AC4][31:16]);
    assign ac4 = {16'd0, cal_reg[CAL_AC3_AC4][15:0]};
    assign ac5 = {16'd0, cal_reg[CAL_AC5_AC6][31:16]};
    assign ac6 = {16'd0, cal_reg[CAL_AC5_AC6][15:0]};
    assign b1  = sext16(cal_reg[CAL_B1_B2][31:16]);
    assign b2  = sext16(cal_reg[CAL_B1_B2][15:0]);
    assign mc  = sext16(cal_reg[CAL_MC_MD][31:16]);
    assign md  = sext16(cal_reg[CAL_MC_MD][15:0]);

    assign num  = {mc[20:0], 11'd0};
    assign pshr = asr32(p_reg, 5'd8);

    always_comb
    begin
        case (cmd.op)
            OP_T_MUL:
            begin
                mul_a = {16'd0, raw_reg[15:0]} - ac6;
                mul_b = ac5;
            end
            OP_P_SQM:
            begin
                mul_a = b6_reg;
                mul_b = b6_reg;
            end
            OP_P_M1:
            begin
                mul_a = b2;
                mul_b = sq_reg;
            end
            OP_P_X1:
            begin
                mul_a = ac2;
                mul_b = b6_reg;
            end
            OP_P_X2:
            begin
                mul_a = ac3;
                mul_b = b6_reg;
            end
            OP_P_B3:
            begin
                mul_a = b1;
                mul_b = sq_reg;
            end
            OP_P_B4M:
            begin
                mul_a = ac4;
                mul_b = tb_reg + B4_BIAS;
            end
            OP_P_B7:
            begin
                mul_a = tc_reg;
                mul_b = B7_SCALE;
            end
            OP_P_PM:
            begin
                mul_a = pshr;
                mul_b = pshr;
            end
            OP_P_PX:
            begin
                mul_a = m_reg;
                mul_b = P_SQ_COEF;
            end
            OP_P_Y1:
            begin
                mul_a = P_LIN_COEF;
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign is_divs         = (cmd.op == OP_T_DIVS) || (cmd.op == OP_P_DIVS);
    assign status.div_zero = (cmd.op == OP_T_DIVS) ? (tb_reg == '0) : (b4_reg == '0);
    assign div_start       = cmd.exec && is_divs && !status.div_zero;

    always_comb
    begin
        if (cmd.op == OP_T_DIVS)
        begin
            div_dividend = num[31] ? (32'd0 - num) : num;
            div_divisor  = tb_reg[31] ? (32'd0 - tb_reg) : tb_reg;
        end
        else
        begin
            div_dividend = m_reg[31] ? m_reg : {m_reg[30:0], 1'b0};
            div_divisor  = b4_reg;
        end
    end

    bsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (status.div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAL_COUNT; i++)
            begin
                cal_reg[i] <= '0;
            end
            b5_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index < CFG_IDX_W'(CAL_COUNT)))
            begin
                cal_reg[cfg_index] <= cfg_data;
            end
            if (cmd.exec && (cmd.op == OP_T_B5))
            begin
                b5_reg <= ta_reg + tc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= in_kind;
            raw_reg  <= in_raw;
        end
        if (cmd.exec)
        begin
            m_reg <= mul_a * mul_b;
            case (cmd.op)
                OP_T_X1:
                begin
                    ta_reg <= asr32(m_reg, 5'd15);
                end
                OP_T_DEN:
                begin
                    tb_reg <= ta_reg + md;
                end
                OP_T_DIVS:
                begin
                    neg_reg <= num[31] ^ tb_reg[31];
                    if (status.div_zero)
                    begin
                        res_value_reg <= '0;
                        res_err_reg   <= 1'b1;
                    end
                end
                OP_T_X2:
                begin
                    tc_reg <= neg_reg ? (32'd0 - div_q) : div_q;
                end
                OP_T_B5:
                begin
                    res_value_reg <= asr32(ta_reg + tc_reg + 32'd8, 5'd4);
                    res_err_reg   <= 1'b0;
                end
                OP_P_B6:
                begin
                    b6_reg <= b5_reg - B6_OFFSET;
                end
                OP_P_SQ:
                begin
                    sq_reg <= asr32(m_reg, 5'd12);
                end
                OP_P_X1:
                begin
                    ta_reg <= asr32(m_reg, 5'd11);
                end
                OP_P_X2:
                begin
                    ta_reg <= ta_reg + asr32(m_reg, 5'd11);
                end
                OP_P_B3:
                begin
                    b3_reg <= asr32({ac1[29:0], 2'b00} + ta_reg + 32'd2, 5'd2);
                    tb_reg <= asr32(m_reg, 5'd13);
                end
                OP_P_X3:
                begin
                    tb_reg <= asr32(tb_reg + asr32(m_reg, 5'd16) + 32'd2, 5'd2);
                end
                OP_P_B4:
                begin
                    b4_reg <= {15'd0, m_reg[31:15]};
                    tc_reg <= {16'd0, raw_reg[23:8]} - b3_reg;
                end
                OP_P_DIVS:
                begin
                    dbl_reg <= m_reg[31];
                    if (status.div_zero)
                    begin
                        res_value_reg <= '0;
                        res_err_reg   <= 1'b1;
                    end
                end
                OP_P_P:
                begin
                    p_reg <= dbl_reg ? {div_q[30:0], 1'b0} : div_q;
                end
                OP_P_Y1:
                begin
                    ta_reg <= asr32(m_reg, 5'd16);
                end
                OP_P_Y2:
                begin
                    ta_reg <= ta_reg + asr32(m_reg, 5'd16) + P_OFFSET;
                end
                OP_P_V:
                begin
                    res_value_reg <= p_reg + asr32(ta_reg, 5'd4);
                    res_err_reg   <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load_out)
        begin
            okind_reg  <= kind_reg;
            ovalue_reg <= res_value_reg;
            oerr_reg   <= res_err_reg;
        end
    end

    assign out_kind  = okind_reg;
    assign out_value = ovalue_reg;
    assign out_err   = oerr_reg;
endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives temperature and pressure readings through the valid/ready channels
// under several calibration sets and checks every result. Readings go in
// bursts with random gaps, and the result side stalls on its own pattern.
// A directed table covers reset values, the published example, extreme
// readings and both zero-divisor cases. Random phases follow, mostly
// temperature/pressure pairs. Results not typed into the table are checked
// against an in-bench compensation model.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bsc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CAL_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CAL_UNUSED_HI = 3'd7;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        err;
    } reading_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        logic                 kind;
        logic [23:0]          raw;
        bit                   typed;
        logic [31:0]          value;
        logic                 err;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bsc_in_if  in_if();
    bsc_out_if out_if();

    barometric_sensor_compensation_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_if),
        .out_item (out_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    logic [31:0] cal [CAL_COUNT];
    logic [31:0] kept_b5;
    reading_t    pending[$];
    row_t        plan[$];
    int          mismatches;
    int          n_temp;
    int          n_press;
    int          n_diverr;
    int          burst_left;
    int          cycle_no;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #3ms;
        $display("Timeout with %0d results outstanding", pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        logic signed [31:0] t;
        t = x;
        return t >>> n;
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic reading_t compensate(input logic kind, input logic [23:0] raw);
        reading_t    r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, up, ut;
        ac1 = sx(cal[CAL_AC1_AC2][31:16]);
        ac2 = sx(cal[CAL_AC1_AC2][15:0]);
        ac3 = sx(cal[CAL_AC3_AC4][31:16]);
        ac4 = {16'd0, cal[CAL_AC3_AC4][15:0]};
        ac5 = {16'd0, cal[CAL_AC5_AC6][31:16]};
        ac6 = {16'd0, cal[CAL_AC5_AC6][15:0]};
        b1  = sx(cal[CAL_B1_B2][31:16]);
        b2  = sx(cal[CAL_B1_B2][15:0]);
        mc  = sx(cal[CAL_MC_MD][31:16]);
        md  = sx(cal[CAL_MC_MD][15:0]);
        r.kind  = kind;
        r.value = '0;
        r.err   = 1'b0;
        if (kind == KIND_TEMP)
        begin
            ut  = {16'd0, raw[15:0]};
            x1  = sra((ut - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 0)
                r.err = 1'b1;
            else
            begin
                x2 = div_trunc(mc << 11, den);
                b5 = x1 + x2;
                kept_b5 = b5;
                r.value = sra(b5 + 32'd8, 4);
            end
        end
        else
        begin
            up = {16'd0, raw[23:8]};
            b6 = kept_b5 - 32'd4000;
            sq = sra(b6 * b6, 12);
            x1 = sra(b2 * sq, 11);
            x2 = sra(ac2 * b6, 11);
            b3 = sra(ac1 * 32'd4 + x1 + x2 + 32'd2, 2);
            x1 = sra(ac3 * b6, 13);
            x2 = sra(b1 * sq, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * 32'd50000;
            if (b4 == 0)
                r.err = 1'b1;
            else
            begin
                if (!b7[31])
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                x1 = sra(p, 8);
                x1 = x1 * x1;
                x1 = sra(x1 * 32'd3038, 16);
                x2 = sra(32'hFFFF_E343 * p, 16);
                r.value = p + sra(x1 + x2 + 32'd3791, 4);
            end
        end
        return r;
    endfunction

    task automatic settle();
        wait (pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < CAL_COUNT)
            cal[idx] = data;
    endtask

    task automatic send_reading(input logic kind, input logic [23:0] raw, input bit typed,
                                input logic [31:0] tv, input logic te);
        reading_t r;
        bit       taken;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                in_if.valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.raw_value <= raw;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            taken = in_if.valid && in_if.ready;
        end
        r = compensate(kind, raw);
        if (typed)
        begin
            r.value = tv;
            r.err   = te;
        end
        pending.push_back(r);
    endtask

    task automatic idle_input();
        @(negedge clk);
        in_if.valid <= 1'b0;
        burst_left = 0;
    endtask

    always @(negedge clk)
    begin
        cycle_no <= cycle_no + 1;
        case ((cycle_no / 300) % 4)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= (cycle_no % 7) < 3;
            2: out_if.ready <= $urandom_range(0, 1);
            default: out_if.ready <= (cycle_no % 61) > 40;
        endcase
    end

    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (out_if.result_kind == KIND_TEMP)
                n_temp++;
            else
                n_press++;
            if (out_if.divide_error)
                n_diverr++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind %0d value %0d err %0d",
                             out_if.result_kind, $signed(out_if.value), out_if.divide_error);
            end
            else
            begin
                e = pending.pop_front();
                if (e.kind !== out_if.result_kind || e.value !== out_if.value
                    || e.err !== out_if.divide_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected kind %0d value %0d err %0d, got kind %0d value %0d err %0d",
                                 e.kind, $signed(e.value), e.err, out_if.result_kind,
                                 $signed(out_if.value), out_if.divide_error);
                end
            end
        end
    end

    initial
    begin
        logic [31:0] set [CAL_COUNT];
        logic        k;
        logic [23:0] raw;
        row_t        row;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_TEMP;
        in_if.raw_value = '0;
        out_if.ready    = 1'b0;
        cycle_no        = 0;
        mismatches      = 0;
        n_temp          = 0;
        n_press         = 0;
        n_diverr        = 0;
        burst_left      = 0;
        kept_b5         = '0;
        foreach (cal[i])
            cal[i] = '0;

        plan.push_back('{0, 0, 0, KIND_PRESS, 24'h123456, 1, 32'd0, 1'b1});
        plan.push_back('{0, 0, 0, KIND_TEMP, 24'hABCDEF, 1, 32'd0, 1'b1});
        plan.push_back('{1, CAL_AC1_AC2, 32'h0198_FFB8, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_AC3_AC4, 32'hC7D1_7FE5, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_AC5_AC6, 32'h7FF5_5A71, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_B1_B2, 32'h182E_0004, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_MC_MD, 32'hDDF9_0B34, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_UNUSED_LO, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_UNUSED_HI, 32'h0000_0000, 0, 0, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_TEMP, 24'h006CFA, 1, 32'd150, 1'b0});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'h5D23A0, 1, 32'd69964, 1'b0});
        plan.push_back('{0, 0, 0, KIND_TEMP, 24'hFF6CFA, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'h000000, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'hFFFFFF, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_TEMP, 24'h000000, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'h5D2300, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_TEMP, 24'h00FFFF, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'h800000, 0, 0, 0});
        plan.push_back('{1, CAL_AC5_AC6, 32'h0000_5A71, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_MC_MD, 32'hDDF9_0000, 0, 0, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_TEMP, 24'h006CFA, 1, 32'd0, 1'b1});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'h5D2300, 0, 0, 0});
        plan.push_back('{1, CAL_AC3_AC4, 32'hC7D1_0000, 0, 0, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'h5D2300, 1, 32'd0, 1'b1});
        plan.push_back('{1, CAL_AC1_AC2, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_AC3_AC4, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_AC5_AC6, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_B1_B2, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
        plan.push_back('{1, CAL_MC_MD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_TEMP, 24'hFFFFFF, 0, 0, 0});
        plan.push_back('{0, 0, 0, KIND_PRESS, 24'hFFFFFF, 0, 0, 0});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                idle_input();
                settle();
                write_cal(row.idx, row.data);
            end
            else
                send_reading(row.kind, row.raw, row.typed, row.value, row.err);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set = '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71, 32'h182E_0004,
                           32'hDDF9_0B34};
                1: set = '{32'h7FFF_8000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_8000,
                           32'h7FFF_8000};
                2: set = '{32'h8000_7FFF, 32'h8000_0001, 32'h0001_FFFF, 32'h8000_7FFF,
                           32'h8000_7FFF};
                3, 4, 5:
                    foreach (set[j])
                        set[j] = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
                default:
                    set = '{{16'($urandom_range(300, 9000)), 16'($signed(-$urandom_range(0, 1500)))},
                            {16'($signed(-$urandom_range(5000, 15000))),
                             16'($urandom_range(30000, 36000))},
                            {16'($urandom_range(24000, 33000)), 16'($urandom_range(15000, 25000))},
                            {16'($urandom_range(5000, 7000)), 16'($urandom_range(1, 60))},
                            {16'($signed(-$urandom_range(8000, 12000))),
                             16'($urandom_range(2000, 3000))}};
            endcase
            idle_input();
            settle();
            foreach (set[j])
                write_cal(CFG_IDX_W'(j), set[j]);
            for (int n = 0; n < 32; n++)
            begin
                if (n == 16)
                begin
                    idle_input();
                    wait (pending.size() == 0);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    raw = $urandom_range(0, 1) ? 24'($urandom())
                                               : {8'($urandom()), 16'($urandom_range(15000, 40000))};
                    send_reading(KIND_TEMP, raw, 0, 0, 0);
                    raw = $urandom_range(0, 1) ? 24'($urandom())
                                               : 24'($urandom_range(24'h40_0000, 24'hA0_0000));
                    send_reading(KIND_PRESS, raw, 0, 0, 0);
                end
                else
                begin
                    k = $urandom_range(0, 1);
                    send_reading(k, 24'($urandom()), 0, 0, 0);
                end
            end
        end

        idle_input();
        settle();
        $display("Covered %0d temperature and %0d pressure results over 8 calibration sets,",
                 n_temp, n_press);
        $display("%0d of them with a zero divisor; %0d mismatches.", n_diverr, mismatches);
        if (mismatches == 0 && pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire

// File: sim.f
design/bsc_pkg.sv
design/bsc_in_if.sv
design/bsc_out_if.sv
design/bsc_div.sv
design/bsc_ctrl.sv
design/bsc_dp.sv
design/barometric_sensor_compensation_top.sv
verif/testbench.sv
